@@ hw/rtl/ffba_pkg.sv @@
`default_nettype none

package ffba_pkg;

	// slots checked per scan cycle, and per write cycle when marking
	localparam int CHUNK     = 16;
	localparam int LOG_CHUNK = 4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_PASTEND = 2'd2
	} st_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan;
		logic mark_alloc;
		logic mark_free;
		logic mark;
		logic push;
		logic found;
		st_t  code;
	} cmd_t;

	typedef struct packed {
		logic alloc;
		logic bad_len;
		logic past_end;
		logic zero_len;
		logic hit;
		logic scan_end;
		logic mark_last;
		logic rsp_free;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/first_fit_bitmap_allocator.sv @@
`default_nettype none

// First-fit run allocator over a bitmap of SLOTS slots, all free after reset.
// One word is taken at a time: an allocate scans the bitmap 16 slots per
// cycle from slot 0 upward, one row of the bitmap memory per cycle, then
// writes the found run one row per cycle. An allocate is checked, scans up
// to SLOTS/16 rows until a run fits, then marks the rows the run covers;
// a free is checked and then marks the rows it covers, and a rejected
// request goes from the check straight to the response. The response waits
// in an output register, so the next word is taken as soon as the response
// is parked there. No clearing pass is needed after reset: each bitmap row
// has a valid flag.
module first_fit_bitmap_allocator #(
	parameter int SLOTS = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic       op,
	input  wire logic [8:0] run_length,
	input  wire logic [7:0] free_offset,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output logic [7:0]      found_offset,
	output logic [1:0]      status
);
	import ffba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffba_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.run_length   (run_length),
		.free_offset  (free_offset),
		.rsp_stall    (rsp_stall),
		.rsp_valid    (rsp_valid),
		.found_offset (found_offset),
		.status       (status)
	);

endmodule

`default_nettype wire

@@ hw/rtl/ffba_ctrl.sv @@
`default_nettype none

module ffba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  ffba_pkg::sts_t     sts,
	output ffba_pkg::cmd_t     cmd
);
	import ffba_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_MARK,
		S_RESP
	} state_t;

	state_t state_q;
	logic   stall_q;
	st_t    code_q;
	logic   found_q;

	assign req_stall = stall_q;

	always_comb begin
		cmd = '0;
		cmd.code = code_q;
		cmd.found = found_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
			end
			S_CHECK: begin
				cmd.scan_start = sts.alloc && !sts.bad_len;
				cmd.mark_free = !sts.alloc && !sts.past_end && !sts.zero_len;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				cmd.mark_alloc = sts.hit;
			end
			S_MARK: begin
				cmd.mark = 1'b1;
			end
			S_RESP: begin
				cmd.push = sts.rsp_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
			code_q  <= ST_OK;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHECK;
						stall_q <= 1'b1;
					end
				end
				S_CHECK: begin
					found_q <= 1'b0;
					code_q  <= ST_OK;
					if (sts.alloc) begin
						if (sts.bad_len) begin
							code_q  <= ST_NOFIT;
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end else if (sts.past_end) begin
						code_q  <= ST_PASTEND;
						state_q <= S_RESP;
					end else if (sts.zero_len) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_MARK;
					end
				end
				S_SCAN: begin
					if (sts.hit) begin
						found_q <= 1'b1;
						code_q  <= ST_OK;
						state_q <= S_MARK;
					end else if (sts.scan_end) begin
						code_q  <= ST_NOFIT;
						state_q <= S_RESP;
					end
				end
				S_MARK: begin
					if (sts.mark_last) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (sts.rsp_free) begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ffba_dpath.sv @@
`default_nettype none

module ffba_dpath #(
	parameter int SLOTS = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  ffba_pkg::cmd_t     cmd,
	output ffba_pkg::sts_t     sts,
	input  wire logic          op,
	input  wire logic [8:0]    run_length,
	input  wire logic [7:0]    free_offset,
	input  wire logic          rsp_stall,
	output logic               rsp_valid,
	output logic [7:0]         found_offset,
	output logic [1:0]         status
);
	import ffba_pkg::*;

	localparam int ROWS = (SLOTS + CHUNK - 1) / CHUNK;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int OW   = $clog2(SLOTS);
	localparam int FW   = $clog2(ROWS * CHUNK + 1);
	localparam int NW   = ((FW > 9) ? FW : 9) + 1;

	// request
	logic          op_q;
	logic [NW-1:0] len_q;
	logic [NW-1:0] off_q;

	// bitmap: one row of CHUNK used bits per address
	logic [CHUNK-1:0] mem [ROWS];
	logic [ROWS-1:0]  row_valid_q;

	// scan
	logic [RW:0]      rd_row_q;
	logic [RW-1:0]    rrow_s1;
	logic             dval_s1;
	logic [CHUNK-1:0] rdata_s1;
	logic             rvld_s1;
	logic [FW-1:0]    free_cnt_q;

	// mark
	logic [NW-1:0] lo_q;
	logic [OW-1:0] pos_q;
	logic [RW-1:0] wr_row_q;

	// response
	logic       rsp_valid_q;
	logic [7:0] found_q;
	st_t        status_q;

	logic                 rd_more;
	logic [CHUNK-1:0]     used;
	logic [CHUNK-1:0]     lu_any;
	logic [LOG_CHUNK-1:0] lu_idx [CHUNK];
	logic [NW-1:0]        run [CHUNK];
	logic [CHUNK-1:0]     fit;
	logic                 hit;
	logic [LOG_CHUNK-1:0] hj;
	logic [NW-1:0]        start;
	logic [NW-1:0]        mstart;
	logic [NW-1:0]        mrow;
	logic [NW-1:0]        hi;
	logic [NW-1:0]        last_row;
	logic [CHUNK-1:0]     sel;
	logic [CHUNK-1:0]     wmask;
	logic [CHUNK-1:0]     wdat;
	logic [OW+7:0]        pos_ext;

	assign rd_more = rd_row_q < (RW+1)'(ROWS);

	// slots past the end of the store count as used
	always_comb begin
		for (int j = 0; j < CHUNK; j++) begin
			used[j] = (rvld_s1 & rdata_s1[j]) |
				(((NW'(rrow_s1) << LOG_CHUNK) + NW'(j)) >= NW'(SLOTS));
		end
	end

	// free run ending at each slot of the chunk, carried from earlier chunks
	always_comb begin
		for (int j = 0; j < CHUNK; j++) begin
			lu_any[j] = 1'b0;
			lu_idx[j] = '0;
			for (int k = 0; k <= j; k++) begin
				if (used[k]) begin
					lu_any[j] = 1'b1;
					lu_idx[j] = LOG_CHUNK'(k);
				end
			end
			run[j] = lu_any[j] ? (NW'(j) - NW'(lu_idx[j]))
				: (NW'(free_cnt_q) + NW'(j) + NW'(1));
			fit[j] = dval_s1 && (run[j] >= len_q);
		end
	end

	always_comb begin
		hj = '0;
		for (int j = CHUNK - 1; j >= 0; j--) begin
			if (fit[j]) begin
				hj = LOG_CHUNK'(j);
			end
		end
	end

	assign hit   = |fit;
	assign start = (NW'(rrow_s1) << LOG_CHUNK) + NW'(hj) + NW'(1) - len_q;

	assign mstart   = cmd.mark_alloc ? start : off_q;
	assign mrow     = mstart >> LOG_CHUNK;
	assign hi       = lo_q + len_q;
	assign last_row = (hi - NW'(1)) >> LOG_CHUNK;

	always_comb begin
		for (int b = 0; b < CHUNK; b++) begin
			sel[b] = (((NW'(wr_row_q) << LOG_CHUNK) + NW'(b)) >= lo_q) &&
				(((NW'(wr_row_q) << LOG_CHUNK) + NW'(b)) < hi);
		end
	end

	// a row never written holds junk: write all of it the first time
	assign wmask = row_valid_q[wr_row_q] ? sel : '1;
	assign wdat  = (op_q == OP_ALLOC) ? sel : '0;

	always_comb begin
		sts           = '0;
		sts.alloc     = op_q == OP_ALLOC;
		sts.bad_len   = (len_q == '0) || (len_q > NW'(SLOTS));
		sts.past_end  = (off_q >= NW'(SLOTS)) || ((off_q + len_q) > NW'(SLOTS));
		sts.zero_len  = len_q == '0;
		sts.hit       = hit;
		sts.scan_end  = dval_s1 && !hit && (rrow_s1 == RW'(ROWS - 1));
		sts.mark_last = NW'(wr_row_q) == last_row;
		sts.rsp_free  = !rsp_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			len_q <= NW'(run_length);
			off_q <= NW'(free_offset);
		end
		if (cmd.mark_alloc || cmd.mark_free) begin
			lo_q     <= mstart;
			wr_row_q <= mrow[RW-1:0];
		end else if (cmd.mark) begin
			wr_row_q <= wr_row_q + RW'(1);
		end
		if (cmd.mark_alloc) begin
			pos_q <= start[OW-1:0];
		end
		if (cmd.scan && rd_more) begin
			rdata_s1 <= mem[rd_row_q[RW-1:0]];
			rvld_s1  <= row_valid_q[rd_row_q[RW-1:0]];
			rrow_s1  <= rd_row_q[RW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mark) begin
			for (int b = 0; b < CHUNK; b++) begin
				if (wmask[b]) begin
					mem[wr_row_q][b] <= wdat[b];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_row_q    <= '0;
			dval_s1     <= 1'b0;
			free_cnt_q  <= '0;
		end else begin
			if (cmd.mark) begin
				row_valid_q[wr_row_q] <= 1'b1;
			end
			if (cmd.scan_start) begin
				rd_row_q   <= '0;
				dval_s1    <= 1'b0;
				free_cnt_q <= '0;
			end else if (cmd.scan) begin
				dval_s1 <= rd_more;
				if (rd_more) begin
					rd_row_q <= rd_row_q + (RW+1)'(1);
				end
				// carry the free run at the top of this chunk into the next
				if (dval_s1) begin
					if (lu_any[CHUNK-1]) begin
						free_cnt_q <= FW'(CHUNK - 1) - FW'(lu_idx[CHUNK-1]);
					end else begin
						free_cnt_q <= free_cnt_q + FW'(CHUNK);
					end
				end
			end
		end
	end

	assign pos_ext = (OW+8)'(pos_q);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			status_q <= cmd.code;
			found_q  <= cmd.found ? pos_ext[7:0] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.push) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign found_offset = found_q;
	assign status       = status_q;

endmodule

`default_nettype wire

@@ tb/tb_first_fit_bitmap_allocator.sv @@
`default_nettype none

module tb_first_fit_bitmap_allocator;
	import ffba_pkg::*;

	localparam int SLOTS = 256;

	typedef struct {
		logic [7:0] offset;
		st_t        code;
	} alloc_rsp_t;

	typedef struct {
		int unsigned first;
		int unsigned len;
	} run_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	logic       op;
	logic [8:0] run_length;
	logic [7:0] free_offset;
	logic       rsp_valid;
	logic       rsp_stall;
	logic [7:0] found_offset;
	logic [1:0] status;

	bit         slot_busy [SLOTS];
	alloc_rsp_t rsp_pending [$];
	run_t       live_runs [$];
	int         errors;
	int         words_sent;
	int         n_placed;
	int         n_nofit;
	int         n_freed;
	int         n_pastend;
	bit         req_gaps_on;
	bit         rsp_gaps_on;

	always #5 clk = ~clk;

	first_fit_bitmap_allocator #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.run_length  (run_length),
		.free_offset (free_offset),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.found_offset(found_offset),
		.status      (status)
	);

	// Apply one accepted word to the shadow bitmap and return the response it should give.
	function automatic alloc_rsp_t apply_word(logic o, int unsigned len, int unsigned first);
		alloc_rsp_t r;
		int unsigned s;
		int unsigned k;
		int unsigned streak;
		int unsigned pos;
		bit found;
		run_t placed;

		r.offset = '0;
		r.code   = ST_OK;
		found    = 1'b0;
		pos      = 0;
		streak   = 0;
		if (o == OP_ALLOC) begin
			if (len >= 1 && len <= SLOTS) begin
				// first run of len free slots ends where the streak reaches len
				for (s = 0; s < SLOTS; s++) begin
					if (!found) begin
						streak = slot_busy[s] ? 0 : streak + 1;
						if (streak == len) begin
							found = 1'b1;
							pos   = s + 1 - len;
						end
					end
				end
			end
			if (found) begin
				for (k = 0; k < len; k++)
					slot_busy[pos + k] = 1'b1;
				r.offset     = pos[7:0];
				placed.first = pos;
				placed.len   = len;
				live_runs.push_back(placed);
				n_placed++;
			end else begin
				r.code = ST_NOFIT;
				n_nofit++;
			end
		end else if (first >= SLOTS || first + len > SLOTS) begin
			r.code = ST_PASTEND;
			n_pastend++;
		end else begin
			for (k = 0; k < len; k++)
				slot_busy[first + k] = 1'b0;
			n_freed++;
		end
		return r;
	endfunction

	task automatic send_word(logic o, logic [8:0] len, logic [7:0] first);
		int gap;

		gap = req_gaps_on ? $urandom_range(0, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid   <= 1'b1;
		op          <= o;
		run_length  <= len;
		free_offset <= first;
		do @(posedge clk); while (req_stall);
		rsp_pending.push_back(apply_word(o, 32'(len), 32'(first)));
		words_sent++;
	endtask

	task automatic test_length_limits();
		send_word(OP_ALLOC, 9'd0, 8'd0);
		send_word(OP_ALLOC, 9'd257, 8'd0);
		send_word(OP_ALLOC, 9'd511, 8'hFF);
		send_word(OP_ALLOC, 9'd1, 8'd0);
		send_word(OP_ALLOC, 9'd256, 8'd0);
		send_word(OP_FREE, 9'd1, 8'd0);
	endtask

	task automatic test_full_store();
		send_word(OP_ALLOC, 9'd256, 8'd0);
		send_word(OP_ALLOC, 9'd1, 8'd0);
		send_word(OP_FREE, 9'd1, 8'd255);
		send_word(OP_ALLOC, 9'd1, 8'd0);
		send_word(OP_FREE, 9'd2, 8'd255);
		send_word(OP_FREE, 9'd256, 8'd1);
		send_word(OP_FREE, 9'd511, 8'd0);
		send_word(OP_FREE, 9'd256, 8'd0);
	endtask

	task automatic test_odd_frees();
		send_word(OP_FREE, 9'd0, 8'd100);
		send_word(OP_FREE, 9'd0, 8'd255);
		send_word(OP_FREE, 9'd32, 8'd16);
	endtask

	task automatic test_fragmentation();
		send_word(OP_ALLOC, 9'd10, 8'd0);
		send_word(OP_ALLOC, 9'd5, 8'd0);
		send_word(OP_FREE, 9'd3, 8'd0);
		// the hole at slot 0 is too short, so this lands after the second run
		send_word(OP_ALLOC, 9'd4, 8'd0);
		send_word(OP_ALLOC, 9'd3, 8'd0);
		send_word(OP_FREE, 9'd256, 8'd0);
	endtask

	task automatic test_random_traffic(int unsigned words);
		int unsigned n;
		int unsigned pick;
		int unsigned len;
		int unsigned first;
		int unsigned idx;
		run_t victim;

		live_runs.delete();
		for (n = 0; n < words; n++) begin
			if (n % 64 == 0) begin
				req_gaps_on = ($urandom_range(0, 3) != 0);
				rsp_gaps_on = ($urandom_range(0, 3) != 0);
			end
			pick = $urandom_range(0, 99);
			if (pick >= 45 && pick < 80 && live_runs.size() > 0) begin
				idx    = $urandom_range(0, live_runs.size() - 1);
				victim = live_runs[idx];
				live_runs.delete(idx);
				send_word(OP_FREE, 9'(victim.len), 8'(victim.first));
			end else if (pick >= 80 && pick < 90) begin
				first = $urandom_range(0, SLOTS - 1);
				len   = $urandom_range(0, SLOTS - first);
				send_word(OP_FREE, 9'(len), 8'(first));
			end else if (pick >= 90 && pick < 96) begin
				first = $urandom_range(0, SLOTS - 1);
				len   = $urandom_range(SLOTS - first + 1, 511);
				send_word(OP_FREE, 9'(len), 8'(first));
			end else if (pick >= 96 && pick < 98) begin
				send_word(OP_FREE, 9'(SLOTS), 8'd0);
				live_runs.delete();
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					len = $urandom_range(1, 16);
				else if (pick < 88)
					len = $urandom_range(17, 64);
				else if (pick < 96)
					len = $urandom_range(65, SLOTS);
				else if (pick < 98)
					len = 0;
				else
					len = $urandom_range(SLOTS + 1, 511);
				send_word(OP_ALLOC, 9'(len), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin : rsp_sink
		int hold;
		alloc_rsp_t want;

		rsp_stall = 1'b0;
		forever begin
			hold = rsp_gaps_on ? $urandom_range(0, 19) : 0;
			@(negedge clk);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			if (rsp_pending.size() == 0) begin
				$error("unexpected response: found_offset %0d status %0d", found_offset, status);
				errors++;
			end else begin
				want = rsp_pending.pop_front();
				if (found_offset !== want.offset) begin
					$error("found_offset: expected %0d, got %0d", want.offset, found_offset);
					errors++;
				end
				if (status !== want.code) begin
					$error("status: expected %0d, got %0d", want.code, status);
					errors++;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_first_fit_bitmap_allocator NOT OK");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		op          = OP_ALLOC;
		run_length  = '0;
		free_offset = '0;
		req_gaps_on = 1'b1;
		rsp_gaps_on = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_length_limits();
		test_full_store();
		test_odd_frees();
		test_fragmentation();
		test_random_traffic(1950);

		@(negedge clk);
		req_valid <= 1'b0;
		wait (rsp_pending.size() == 0);
		// let a stray extra response show up
		repeat (64) @(posedge clk);

		$display("%0d words: %0d runs placed, %0d allocations refused", words_sent, n_placed,
			n_nofit);
		$display("%0d frees applied, %0d frees rejected past the end", n_freed, n_pastend);
		if (errors == 0)
			$display("tb_first_fit_bitmap_allocator OK");
		else
			$display("tb_first_fit_bitmap_allocator NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
